/* src/hfd_pkg.sv */
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared constants and types of the huffman stream decoder.
// ----------------------------------------------------------------------------
package hfd_pkg;

    localparam int SYMBOL_COUNT  = 256;
    localparam int NODE_CAPACITY = 511;
    localparam int STACK_DEPTH   = 256;

    // tag byte that opens a leaf in the tree header
    localparam logic [7:0] LEAF_TAG = 8'h31;
    localparam int MSB_INDEX = 7;

    // request from the sequencer to the result stage
    typedef struct packed {
        logic       sym_en;
        logic       flush_en;
        logic       fault_en;
        logic [7:0] sym;
        logic       done;
    } res_req_t;

endpackage

/* src/hfd_node_store.sv */
// ----------------------------------------------------------------------------
// hfd_node_store
// Code tree table: leaf flag and symbol, left child and right child held in
// three memories that share one read address, each with registered read data.
// ----------------------------------------------------------------------------
module hfd_node_store #(
    parameter int NODE_CAPACITY = hfd_pkg::NODE_CAPACITY,
    parameter int NODE_W        = $clog2(NODE_CAPACITY)
) (
    input  logic              clk,
    input  logic              kind_we,
    input  logic [NODE_W-1:0] kind_addr,
    input  logic              kind_leaf,
    input  logic [7:0]        kind_sym,
    input  logic              left_we,
    input  logic              right_we,
    input  logic [NODE_W-1:0] child_addr,
    input  logic [NODE_W-1:0] child_data,
    input  logic [NODE_W-1:0] rd_addr,
    output logic              rd_leaf,
    output logic [7:0]        rd_sym,
    output logic [NODE_W-1:0] rd_left,
    output logic [NODE_W-1:0] rd_right
);

    logic [8:0]        kind_mem  [NODE_CAPACITY];
    logic [NODE_W-1:0] left_mem  [NODE_CAPACITY];
    logic [NODE_W-1:0] right_mem [NODE_CAPACITY];

    logic [8:0]        rd_kind_reg;
    logic [NODE_W-1:0] rd_left_reg;
    logic [NODE_W-1:0] rd_right_reg;

    always_ff @(posedge clk)
    begin
        if (kind_we)
        begin
            kind_mem[kind_addr] <= {kind_leaf, kind_sym};
        end
        rd_kind_reg <= kind_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[child_addr] <= child_data;
        end
        rd_left_reg <= left_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (right_we)
        begin
            right_mem[child_addr] <= child_data;
        end
        rd_right_reg <= right_mem[rd_addr];
    end

    assign rd_leaf  = rd_kind_reg[8];
    assign rd_sym   = rd_kind_reg[7:0];
    assign rd_left  = rd_left_reg;
    assign rd_right = rd_right_reg;

endmodule

/* src/hfd_node_stack.sv */
// ----------------------------------------------------------------------------
// hfd_node_stack
// Stack of internal nodes still waiting for a child: node index plus a flag
// set once the left child is attached. One write port, one registered read.
// ----------------------------------------------------------------------------
module hfd_node_stack #(
    parameter int STACK_DEPTH = hfd_pkg::STACK_DEPTH,
    parameter int NODE_W      = 9,
    parameter int STK_AW      = $clog2(STACK_DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [STK_AW-1:0] waddr,
    input  logic              wside,
    input  logic [NODE_W-1:0] wnode,
    input  logic [STK_AW-1:0] raddr,
    output logic              rside,
    output logic [NODE_W-1:0] rnode
);

    logic [NODE_W:0] stack_mem [STACK_DEPTH];
    logic [NODE_W:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stack_mem[waddr] <= {wside, wnode};
        end
        rdata_reg <= stack_mem[raddr];
    end

    assign rside = rdata_reg[NODE_W];
    assign rnode = rdata_reg[NODE_W-1:0];

endmodule

/* src/hfd_out_stage.sv */
// ----------------------------------------------------------------------------
// hfd_out_stage
// Result stage: one symbol is held back until the next one of the same byte
// or the end of the byte is known, so that the last word carries its flag.
// ----------------------------------------------------------------------------
module hfd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  hfd_pkg::res_req_t req,
    output logic             stage_free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       symbol,
    output logic             last_of_run,
    output logic             file_done,
    output logic             fault
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_sym_reg, out_sym_next;
    logic       out_last_reg, out_last_next;
    logic       out_done_reg, out_done_next;
    logic       out_fault_reg, out_fault_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_sym_reg, pend_sym_next;
    logic       pend_done_reg, pend_done_next;

    assign stage_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        out_fault_next  = out_fault_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;

        if (stage_free)
        begin
            if (req.fault_en)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = 8'h00;
                out_last_next  = 1'b1;
                out_done_next  = 1'b0;
                out_fault_next = 1'b1;
            end
            else if (req.sym_en)
            begin
                // the held symbol is not the last of its byte
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = pend_sym_reg;
                    out_last_next  = 1'b0;
                    out_done_next  = pend_done_reg;
                    out_fault_next = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_sym_next   = req.sym;
                pend_done_next  = req.done;
            end
            else if (req.flush_en)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = pend_sym_reg;
                    out_last_next  = 1'b1;
                    out_done_next  = pend_done_reg;
                    out_fault_next = 1'b0;
                end
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sym_reg   <= out_sym_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
        out_fault_reg <= out_fault_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
    end

    assign out_valid   = out_valid_reg;
    assign symbol      = out_sym_reg;
    assign last_of_run = out_last_reg;
    assign file_done   = out_done_reg;
    assign fault       = out_fault_reg;

    // a fault word closes its byte and never completes the file
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fault_reg) |-> (out_last_reg && !out_done_reg))
        else $error("fault word without last flag or with done flag");

    // a held symbol is pushed out when a new one of the same byte arrives
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_free && req.sym_en && !req.fault_en && pend_valid_reg)
            |=> (out_valid_reg && !out_last_reg))
        else $error("held symbol lost");

endmodule

/* src/huffman_stream_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// Decodes a compressed byte stream: preorder tree header, 4-byte count, data.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one byte of the file per word;
// start_of_file on the first byte clears the parser. Output channel
// (out_valid/out_ready): one decoded symbol per word, with last_of_run on the
// last word caused by an input byte, file_done on the symbol that completes
// the count, and fault when the header overflowed the node table or stack.
// One item at a time; in_ready is high only while the sequencer is idle.
// A header tag byte takes a stack read, a node write and, for an internal
// node, a push; a leaf symbol byte and count bytes are taken on acceptance.
// A data byte takes set-up (current node and root reads), then per bit
// walked a node table read and its evaluation, an emit step per symbol found
// and a flush step to close the byte; the dependent read per bit limits the byte rate.
// A symbol is held in the result stage until the next symbol of the same
// byte or the byte's end is known. When out_ready is low and a word is held,
// the sequencer stalls in its emit, flush or fault step. Reset clears all
// control state; the node table and stack memories are not cleared.
// ----------------------------------------------------------------------------
module huffman_stream_decoder #(
    parameter int SYMBOL_COUNT  = hfd_pkg::SYMBOL_COUNT,
    parameter int NODE_CAPACITY = hfd_pkg::NODE_CAPACITY,
    parameter int STACK_DEPTH   = hfd_pkg::STACK_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       start_of_file,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] symbol,
    output logic       last_of_run,
    output logic       file_done,
    output logic       fault
);

    localparam int NODE_W  = $clog2(NODE_CAPACITY);
    localparam int CMP_W   = NODE_W + 1;
    localparam int NUSED_W = $clog2(NODE_CAPACITY + 1);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int LVL_W   = $clog2(STACK_DEPTH + 1);

    typedef enum logic [5:0] {
        PH_TREE     = 6'b000001,
        PH_LEAF_SYM = 6'b000010,
        PH_COUNT    = 6'b000100,
        PH_DATA     = 6'b001000,
        PH_DONE     = 6'b010000,
        PH_FAULT    = 6'b100000
    } phase_t;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_TREE_WR = 10'b0000000010,
        S_PUSH    = 10'b0000000100,
        S_FAULT   = 10'b0000001000,
        S_CUR     = 10'b0000010000,
        S_ROOT    = 10'b0000100000,
        S_BIT     = 10'b0001000000,
        S_EVAL    = 10'b0010000000,
        S_EMIT    = 10'b0100000000,
        S_FLUSH   = 10'b1000000000
    } state_t;

    // symbol byte reduced modulo the alphabet size by shift and subtract
    function automatic logic [7:0] sym_mod(input logic [7:0] b);
        logic [15:0] rem;
        logic [15:0] dvs;
        rem = {8'h00, b};
        for (int k = 7; k >= 0; k--)
        begin
            dvs = 16'(SYMBOL_COUNT) << k;
            if (rem >= dvs)
            begin
                rem = rem - dvs;
            end
        end
        return rem[7:0];
    endfunction

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         byte_reg, byte_next;
    logic [NUSED_W-1:0] nodes_used_reg, nodes_used_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [1:0]         count_idx_reg, count_idx_next;
    logic [31:0]        symbols_left_reg, symbols_left_next;
    logic [NODE_W-1:0]  cur_node_reg, cur_node_next;
    logic [NODE_W-1:0]  cur_left_reg, cur_left_next;
    logic [NODE_W-1:0]  cur_right_reg, cur_right_next;
    logic               root_leaf_reg, root_leaf_next;
    logic [7:0]         root_sym_reg, root_sym_next;
    logic [NODE_W-1:0]  root_left_reg, root_left_next;
    logic [NODE_W-1:0]  root_right_reg, root_right_next;
    logic [2:0]         bit_reg, bit_next;
    logic [NODE_W-1:0]  new_node_reg, new_node_next;
    logic [7:0]         emit_sym_reg, emit_sym_next;

    logic               accept;
    phase_t             eff_phase;
    logic [NUSED_W-1:0] eff_nodes;
    logic [LVL_W-1:0]   eff_level;
    logic [LVL_W-1:0]   eff_lvl_dec;
    logic [LVL_W-1:0]   lvl_dec;
    logic [1:0]         eff_cidx;
    logic [31:0]        eff_sleft;
    logic [31:0]        count_value;
    logic [NUSED_W-1:0] nu_dec;
    logic [NODE_W-1:0]  walk_raw;
    logic [NODE_W-1:0]  walk_addr;
    logic               new_is_leaf;

    logic               kind_we;
    logic [NODE_W-1:0]  kind_addr;
    logic               kind_leaf;
    logic [7:0]         kind_sym;
    logic               left_we;
    logic               right_we;
    logic [NODE_W-1:0]  child_addr;
    logic [NODE_W-1:0]  node_raddr;
    logic               rd_leaf;
    logic [7:0]         rd_sym;
    logic [NODE_W-1:0]  rd_left;
    logic [NODE_W-1:0]  rd_right;

    logic               stk_we;
    logic [STK_AW-1:0]  stk_waddr;
    logic               stk_wside;
    logic [NODE_W-1:0]  stk_wnode;
    logic               top_side;
    logic [NODE_W-1:0]  top_node;

    hfd_pkg::res_req_t  req;
    logic               stage_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // parser state as seen after an optional start-of-file clear
    assign eff_phase   = start_of_file ? PH_TREE : phase_reg;
    assign eff_nodes   = start_of_file ? '0 : nodes_used_reg;
    assign eff_level   = start_of_file ? '0 : level_reg;
    assign eff_cidx    = start_of_file ? 2'd0 : count_idx_reg;
    assign eff_sleft   = start_of_file ? 32'd0 : symbols_left_reg;
    assign eff_lvl_dec = eff_level - LVL_W'(1);
    assign lvl_dec     = level_reg - LVL_W'(1);
    assign nu_dec      = nodes_used_reg - NUSED_W'(1);
    assign count_value = eff_sleft | (32'(data_byte) << {eff_cidx, 3'b000});
    assign new_is_leaf = (byte_reg == hfd_pkg::LEAF_TAG);

    // child index beyond the table reads as the root
    assign walk_raw  = byte_reg[bit_reg] ? cur_right_reg : cur_left_reg;
    assign walk_addr = (CMP_W'(walk_raw) >= CMP_W'(NODE_CAPACITY)) ? '0 : walk_raw;

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        byte_next         = byte_reg;
        nodes_used_next   = nodes_used_reg;
        level_next        = level_reg;
        count_idx_next    = count_idx_reg;
        symbols_left_next = symbols_left_reg;
        cur_node_next     = cur_node_reg;
        cur_left_next     = cur_left_reg;
        cur_right_next    = cur_right_reg;
        root_leaf_next    = root_leaf_reg;
        root_sym_next     = root_sym_reg;
        root_left_next    = root_left_reg;
        root_right_next   = root_right_reg;
        bit_next          = bit_reg;
        new_node_next     = new_node_reg;
        emit_sym_next     = emit_sym_reg;

        kind_we    = 1'b0;
        kind_addr  = new_node_reg;
        kind_leaf  = new_is_leaf;
        kind_sym   = 8'h00;
        left_we    = 1'b0;
        right_we   = 1'b0;
        child_addr = top_node;
        node_raddr = cur_node_reg;
        stk_we     = 1'b0;
        stk_waddr  = lvl_dec[STK_AW-1:0];
        stk_wside  = 1'b1;
        stk_wnode  = top_node;

        req          = '0;
        req.sym      = emit_sym_reg;
        req.done     = (symbols_left_reg == 32'd1);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    byte_next         = data_byte;
                    phase_next        = eff_phase;
                    nodes_used_next   = eff_nodes;
                    level_next        = eff_level;
                    count_idx_next    = eff_cidx;
                    symbols_left_next = eff_sleft;
                    if (start_of_file)
                    begin
                        cur_node_next = '0;
                    end
                    case (eff_phase)
                        PH_TREE:
                        begin
                            new_node_next = eff_nodes[NODE_W-1:0];
                            if (eff_nodes >= NUSED_W'(NODE_CAPACITY))
                            begin
                                phase_next = PH_FAULT;
                                state_next = S_FAULT;
                            end
                            else
                            begin
                                state_next = S_TREE_WR;
                            end
                        end
                        PH_LEAF_SYM:
                        begin
                            kind_we    = 1'b1;
                            kind_addr  = nu_dec[NODE_W-1:0];
                            kind_leaf  = 1'b1;
                            kind_sym   = sym_mod(data_byte);
                            phase_next = (level_reg == '0) ? PH_COUNT : PH_TREE;
                        end
                        PH_COUNT:
                        begin
                            symbols_left_next = count_value;
                            count_idx_next    = eff_cidx + 2'd1;
                            if (eff_cidx == 2'd3)
                            begin
                                // zero or negative count gives no output
                                if (count_value == 32'd0 || count_value[31])
                                begin
                                    symbols_left_next = 32'd0;
                                    phase_next        = PH_DONE;
                                end
                                else
                                begin
                                    phase_next    = PH_DATA;
                                    cur_node_next = '0;
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            bit_next   = 3'(hfd_pkg::MSB_INDEX);
                            state_next = S_CUR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_TREE_WR:
            begin
                kind_we         = 1'b1;
                nodes_used_next = NUSED_W'(new_node_reg) + NUSED_W'(1);
                if (new_node_reg != '0 && level_reg != '0)
                begin
                    if (!top_side)
                    begin
                        left_we = 1'b1;
                        stk_we  = 1'b1;
                    end
                    else
                    begin
                        right_we   = 1'b1;
                        level_next = lvl_dec;
                    end
                end
                if (new_is_leaf)
                begin
                    phase_next = PH_LEAF_SYM;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                if (level_reg >= LVL_W'(STACK_DEPTH))
                begin
                    phase_next = PH_FAULT;
                    state_next = S_FAULT;
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = level_reg[STK_AW-1:0];
                    stk_wside  = 1'b0;
                    stk_wnode  = new_node_reg;
                    level_next = level_reg + LVL_W'(1);
                    state_next = S_IDLE;
                end
            end

            S_FAULT:
            begin
                req.fault_en = 1'b1;
                if (stage_free)
                begin
                    state_next = S_IDLE;
                end
            end

            S_CUR:
            begin
                cur_left_next  = rd_left;
                cur_right_next = rd_right;
                node_raddr     = '0;
                state_next     = S_ROOT;
            end

            S_ROOT:
            begin
                root_leaf_next  = rd_leaf;
                root_sym_next   = rd_sym;
                root_left_next  = rd_left;
                root_right_next = rd_right;
                state_next      = S_BIT;
            end

            S_BIT:
            begin
                node_raddr = walk_addr;
                if (symbols_left_reg == 32'd0)
                begin
                    state_next = S_FLUSH;
                end
                else if (root_leaf_reg)
                begin
                    // single leaf tree: every bit gives the root symbol
                    emit_sym_next = root_sym_reg;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cur_node_next = walk_addr;
                    state_next    = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (rd_leaf)
                begin
                    emit_sym_next  = rd_sym;
                    cur_node_next  = '0;
                    cur_left_next  = root_left_reg;
                    cur_right_next = root_right_reg;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cur_left_next  = rd_left;
                    cur_right_next = rd_right;
                    if (bit_reg == 3'd0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 3'd1;
                        state_next = S_BIT;
                    end
                end
            end

            S_EMIT:
            begin
                req.sym_en = 1'b1;
                if (stage_free)
                begin
                    symbols_left_next = symbols_left_reg - 32'd1;
                    if (bit_reg == 3'd0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 3'd1;
                        state_next = S_BIT;
                    end
                end
            end

            S_FLUSH:
            begin
                req.flush_en = 1'b1;
                if (stage_free)
                begin
                    if (symbols_left_reg == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_TREE;
            nodes_used_reg   <= '0;
            level_reg        <= '0;
            count_idx_reg    <= 2'd0;
            symbols_left_reg <= 32'd0;
            cur_node_reg     <= '0;
            bit_reg          <= 3'd0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            nodes_used_reg   <= nodes_used_next;
            level_reg        <= level_next;
            count_idx_reg    <= count_idx_next;
            symbols_left_reg <= symbols_left_next;
            cur_node_reg     <= cur_node_next;
            bit_reg          <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        cur_left_reg   <= cur_left_next;
        cur_right_reg  <= cur_right_next;
        root_leaf_reg  <= root_leaf_next;
        root_sym_reg   <= root_sym_next;
        root_left_reg  <= root_left_next;
        root_right_reg <= root_right_next;
        new_node_reg   <= new_node_next;
        emit_sym_reg   <= emit_sym_next;
    end

    hfd_node_store #(
        .NODE_CAPACITY (NODE_CAPACITY),
        .NODE_W        (NODE_W)
    ) u_node_store (
        .clk        (clk),
        .kind_we    (kind_we),
        .kind_addr  (kind_addr),
        .kind_leaf  (kind_leaf),
        .kind_sym   (kind_sym),
        .left_we    (left_we),
        .right_we   (right_we),
        .child_addr (child_addr),
        .child_data (new_node_reg),
        .rd_addr    (node_raddr),
        .rd_leaf    (rd_leaf),
        .rd_sym     (rd_sym),
        .rd_left    (rd_left),
        .rd_right   (rd_right)
    );

    hfd_node_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .NODE_W      (NODE_W),
        .STK_AW      (STK_AW)
    ) u_node_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wside (stk_wside),
        .wnode (stk_wnode),
        .raddr (eff_lvl_dec[STK_AW-1:0]),
        .rside (top_side),
        .rnode (top_node)
    );

    hfd_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .stage_free  (stage_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol      (symbol),
        .last_of_run (last_of_run),
        .file_done   (file_done),
        .fault       (fault)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("open node stack level beyond its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg <= NUSED_W'(NODE_CAPACITY))
        else $error("node count beyond table capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (symbols_left_reg != 32'd0))
        else $error("symbol emitted after the count was reached");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && phase_reg == PH_DATA)
            |-> (symbols_left_reg != 32'd0 && !symbols_left_reg[31]))
        else $error("data phase idle with no symbols left");

endmodule
